// File: rtl/serial_can_frame_parser_unit_assert.svh
// Assertion macros used by the parser RTL.
`ifndef SERIAL_CAN_FRAME_PARSER_UNIT_ASSERT_SVH
`define SERIAL_CAN_FRAME_PARSER_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SCFP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scfp check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SCFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scfp check failed");

`endif

// File: rtl/scfp_pkg.sv
package scfp_pkg;

    // Frame geometry.
    localparam int unsigned MAX_DATA_BYTES = 8;
    localparam int unsigned IDX_W          = $clog2(MAX_DATA_BYTES);
    localparam int unsigned PAYLOAD_W      = 8 * MAX_DATA_BYTES;
    localparam logic [3:0]  LEN_MASK       = 4'h0F;
    localparam logic [3:0]  MAX_LEN        = 4'(MAX_DATA_BYTES);

    // Configuration port.
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_START_MARKER  = 2'd0,
        REG_END_MARKER    = 2'd1,
        REG_ID_FILTER     = 2'd2,
        REG_FILTER_ENABLE = 2'd3
    } t_reg_idx;

    localparam logic [7:0]  START_MARKER_RST = 8'd170;
    localparam logic [7:0]  END_MARKER_RST   = 8'd85;
    localparam logic [31:0] ID_FILTER_RST    = 32'd0;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_GOOD     = 2'd1,
        ST_FILTERED = 2'd2,
        ST_BAD_END  = 2'd3
    } t_status;

    // Parser phases, one-hot.
    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_INFO = 5'b00010,
        PH_ID   = 5'b00100,
        PH_DATA = 5'b01000,
        PH_END  = 5'b10000
    } t_phase;

endpackage

// File: rtl/scfp_in_if.sv
// Channel that carries received serial bytes.
interface scfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/scfp_out_if.sv
// Channel that carries one parse result per received byte.
interface scfp_out_if;
    logic                           valid;
    logic                           ready;
    scfp_pkg::t_status              status;
    logic [3:0]                     frame_length;
    logic [15:0]                    frame_id;
    logic [scfp_pkg::PAYLOAD_W-1:0] frame_payload;

    modport source (output valid, output status, output frame_length,
                    output frame_id, output frame_payload, input ready);
    modport sink   (input valid, input status, input frame_length,
                    input frame_id, input frame_payload, output ready);
endinterface

// File: rtl/serial_can_frame_parser_unit.sv
// Serial CAN adapter frame parser. Every received byte item yields exactly one
// result item: no frame finished, frame good (length, 16-bit ID, payload),
// frame filtered (given at the second ID byte), or bad end marker. The block
// takes one byte per clock cycle while input ready is high; a byte's state
// update and result are formed in the cycle it is accepted, and the result is
// registered in the output or skid register. This two-entry output stage lets
// a byte be accepted while an earlier result waits, so input ready only drops
// after two results are left untaken. Configuration is written through the APB
// port (start marker, end marker, ID filter, filter enable at byte addresses
// 0, 4, 8, 12); the user must do so only while the block is idle (unchecked).
`include "serial_can_frame_parser_unit_assert.svh"

module serial_can_frame_parser_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    scfp_in_if.sink                       rx_if,
    scfp_out_if.source                    res_if,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scfp_pkg::PADDR_W-1:0]  paddr,
    input  logic [scfp_pkg::PDATA_W-1:0]  pwdata,
    output logic [scfp_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    typedef struct packed {
        scfp_pkg::t_status              status;
        logic [3:0]                     frame_length;
        logic [15:0]                    frame_id;
        logic [scfp_pkg::PAYLOAD_W-1:0] frame_payload;
    } t_result;

    // Configuration registers.
    logic [7:0]  r_start_marker;
    logic [7:0]  r_end_marker;
    logic [31:0] r_id_filter;
    logic        r_filter_enable;

    // Parser state.
    scfp_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_byte_count, n_byte_count;
    logic [3:0]       r_exp_len, n_exp_len;
    logic [15:0]      r_rx_id, n_rx_id;
    logic [7:0]       r_data [scfp_pkg::MAX_DATA_BYTES];

    // Output stage.
    t_result r_out, r_skid, n_res;
    logic    r_out_valid, r_skid_valid;

    logic       in_accept;
    logic       out_free;
    logic       cfg_write;
    logic       data_write;
    logic       data_clear;
    logic [3:0] len_nibble;
    logic [3:0] count_inc;
    logic [31:0] id32;
    logic       end_accept;
    logic       data_count_ok;
    scfp_pkg::t_reg_idx cfg_idx;

    assign pready    = 1'b1;
    assign cfg_idx   = scfp_pkg::t_reg_idx'(paddr[scfp_pkg::PADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Register write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker  <= scfp_pkg::START_MARKER_RST;
            r_end_marker    <= scfp_pkg::END_MARKER_RST;
            r_id_filter     <= scfp_pkg::ID_FILTER_RST;
            r_filter_enable <= 1'b0;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                scfp_pkg::REG_START_MARKER:  r_start_marker  <= pwdata[7:0];
                scfp_pkg::REG_END_MARKER:    r_end_marker    <= pwdata[7:0];
                scfp_pkg::REG_ID_FILTER:     r_id_filter     <= pwdata[31:0];
                scfp_pkg::REG_FILTER_ENABLE: r_filter_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read.
    always_comb begin
        unique case (cfg_idx)
            scfp_pkg::REG_START_MARKER:  prdata = {24'd0, r_start_marker};
            scfp_pkg::REG_END_MARKER:    prdata = {24'd0, r_end_marker};
            scfp_pkg::REG_ID_FILTER:     prdata = r_id_filter;
            scfp_pkg::REG_FILTER_ENABLE: prdata = {31'd0, r_filter_enable};
            default:                     prdata = '0;
        endcase
    end

    // Handshake: the skid register must be empty to take another byte.
    assign rx_if.ready = !r_skid_valid;
    assign in_accept   = rx_if.valid && rx_if.ready;
    assign out_free    = !r_out_valid || res_if.ready;

    assign len_nibble = rx_if.rx_byte[3:0] & scfp_pkg::LEN_MASK;
    assign count_inc  = r_byte_count + 4'd1;
    assign id32       = {8'd0, rx_if.rx_byte, 8'd0, r_rx_id[7:0]};

    // Next state and result for the byte on the input.
    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_exp_len    = r_exp_len;
        n_rx_id      = r_rx_id;
        data_write   = 1'b0;
        data_clear   = 1'b0;
        n_res        = '{status: scfp_pkg::ST_NONE, frame_length: 4'd0,
                         frame_id: 16'd0, frame_payload: '0};
        unique case (r_phase)
            scfp_pkg::PH_INFO: begin
                n_exp_len    = (len_nibble > scfp_pkg::MAX_LEN) ? scfp_pkg::MAX_LEN
                                                                 : len_nibble;
                data_clear   = 1'b1;
                n_rx_id      = 16'd0;
                n_byte_count = 4'd0;
                n_phase      = scfp_pkg::PH_ID;
            end
            scfp_pkg::PH_ID: begin
                if (r_byte_count == 4'd0) begin
                    n_rx_id      = {r_rx_id[15:8], rx_if.rx_byte};
                    n_byte_count = 4'd1;
                end else begin
                    n_rx_id      = {rx_if.rx_byte, r_rx_id[7:0]};
                    n_byte_count = 4'd0;
                    priority if (r_filter_enable && (id32 != r_id_filter)) begin
                        n_phase = scfp_pkg::PH_HUNT;
                        n_res   = '{status: scfp_pkg::ST_FILTERED,
                                    frame_length: r_exp_len,
                                    frame_id: {rx_if.rx_byte, r_rx_id[7:0]},
                                    frame_payload: '0};
                    end else if (r_exp_len == 4'd0) begin
                        n_phase = scfp_pkg::PH_END;
                    end else begin
                        n_phase = scfp_pkg::PH_DATA;
                    end
                end
            end
            scfp_pkg::PH_DATA: begin
                data_write = 1'b1;
                if (count_inc >= r_exp_len) begin
                    n_byte_count = 4'd0;
                    n_phase      = scfp_pkg::PH_END;
                end else begin
                    n_byte_count = count_inc;
                end
            end
            scfp_pkg::PH_END: begin
                n_phase = scfp_pkg::PH_HUNT;
                if (rx_if.rx_byte == r_end_marker) begin
                    n_res.status       = scfp_pkg::ST_GOOD;
                    n_res.frame_length = r_exp_len;
                    n_res.frame_id     = r_rx_id;
                    for (int i = 0; i < scfp_pkg::MAX_DATA_BYTES; i++) begin
                        if (4'(i) < r_exp_len) begin
                            n_res.frame_payload[8*i +: 8] = r_data[i];
                        end
                    end
                end else begin
                    n_res.status = scfp_pkg::ST_BAD_END;
                end
            end
            default: begin
                n_phase = (rx_if.rx_byte == r_start_marker) ? scfp_pkg::PH_INFO
                                                             : scfp_pkg::PH_HUNT;
            end
        endcase
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= scfp_pkg::PH_HUNT;
            r_byte_count <= 4'd0;
            r_exp_len    <= 4'd0;
            r_rx_id      <= 16'd0;
        end else if (in_accept) begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_exp_len    <= n_exp_len;
            r_rx_id      <= n_rx_id;
        end
    end

    // Data byte store: cleared at the info byte, one byte written per data byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < scfp_pkg::MAX_DATA_BYTES; i++) begin
                r_data[i] <= 8'd0;
            end
        end else if (in_accept && data_clear) begin
            for (int i = 0; i < scfp_pkg::MAX_DATA_BYTES; i++) begin
                r_data[i] <= 8'd0;
            end
        end else if (in_accept && data_write) begin
            r_data[r_byte_count[scfp_pkg::IDX_W-1:0]] <= rx_if.rx_byte;
        end
    end

    // Output register and skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_accept;
                end
            end else if (in_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end
        if (!out_free && in_accept) begin
            r_skid <= n_res;
        end
    end

    assign res_if.valid         = r_out_valid;
    assign res_if.status        = r_out.status;
    assign res_if.frame_length  = r_out.frame_length;
    assign res_if.frame_id      = r_out.frame_id;
    assign res_if.frame_payload = r_out.frame_payload;

    // Terms used by the checks.
    assign end_accept    = in_accept && (r_phase == scfp_pkg::PH_END);
    assign data_count_ok = (r_byte_count < r_exp_len) && (r_exp_len <= scfp_pkg::MAX_LEN);

    // Checks.
    `SCFP_ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `SCFP_ASSERT_NEXT(a_end_returns_hunt, i_clk, i_rst_n, end_accept, r_phase == scfp_pkg::PH_HUNT)
    `SCFP_ASSERT_SAME(a_data_count_bound, i_clk, i_rst_n, r_phase == scfp_pkg::PH_DATA, data_count_ok)

endmodule
